@@ design/ultrasonic_echo_ranger_defines.svh @@
// Assertion macros shared by the echo ranger RTL.
// Used by uer_seq.sv and ultrasonic_echo_ranger.sv; needs a clock named clock and reset named reset.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Checked at every edge outside reset.
`define UER_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define UER_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/uer_pkg.sv @@
// Types, codes and constants for the ultrasonic echo ranger.
// No dependencies; imported by uer_seq and ultrasonic_echo_ranger.
package uer_pkg;

   localparam int CountWidth = 24;                   // phase and echo counters (8..32)
   localparam int LimitWidth = 24;                   // configuration register width
   localparam int ProdWidth  = CountWidth + LimitWidth;
   localparam int CmpWidth   = 32;
   localparam int DistWidth  = 24;
   localparam int ScaleShift = 16;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
   localparam logic [DistWidth-1:0]  DistMax  = {DistWidth{1'b1}};

   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CsrPreLow   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrTrigger  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSettle   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrTimeout  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrScale    = 3'd4;

   localparam logic [LimitWidth-1:0] PreLowReset  = 24'd2000;
   localparam logic [LimitWidth-1:0] TriggerReset = 24'd15;
   localparam logic [LimitWidth-1:0] SettleReset  = 24'd500;
   localparam logic [LimitWidth-1:0] TimeoutReset = 24'd50000;
   localparam logic [LimitWidth-1:0] ScaleReset   = 24'd287728;

   typedef enum logic [1:0] {
      StatusOk      = 2'd0,
      StatusNoRise  = 2'd1,
      StatusTooLong = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PhIdle   = 3'd0,
      PhPreLow = 3'd1,
      PhTrig   = 3'd2,
      PhSettle = 3'd3,
      PhRise   = 3'd4,
      PhWidth  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [LimitWidth-1:0] pre_low_ticks;
      logic [LimitWidth-1:0] trigger_ticks;
      logic [LimitWidth-1:0] settle_ticks;
      logic [LimitWidth-1:0] timeout_ticks;
      logic [LimitWidth-1:0] distance_scale;
   } cfg_type;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 busy_res;
      logic                 done_res;
      logic [1:0]           status;
      logic [DistWidth-1:0] distance;
   } rsp_type;

endpackage

@@ design/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: CSR bank, sequencer and result register.
// Depends on uer_pkg, uer_seq and ultrasonic_echo_ranger_defines.svh.
//
//   channel   ports                        direction  word
//   req       req_valid/req_ready/req_data in         one tick: start_req, echo_level
//   rsp       rsp_valid/rsp_ready/rsp_data out        one result per tick
//   csr       csr_we/csr_index/csr_wdata   in         24-bit register write, no wait
//
// One word in, one word out, one cycle each; a word is taken every cycle the result
// register is empty or being drained. The result register presents the result in the cycle after the word is taken.
// Distance is one 24 x 24 product of echo width and scale, taken on the falling tick.
// Synchronous reset puts the sequencer in idle and loads the register defaults.
// A stalled rsp side holds its word; req_ready drops until it drains.
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger import uer_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [LimitWidth-1:0]    csr_wdata
);

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    step;
   rsp_type res;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_low_ticks  <= PreLowReset;
         cfg_ff.trigger_ticks  <= TriggerReset;
         cfg_ff.settle_ticks   <= SettleReset;
         cfg_ff.timeout_ticks  <= TimeoutReset;
         cfg_ff.distance_scale <= ScaleReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrPreLow:  cfg_ff.pre_low_ticks  <= csr_wdata;
            CsrTrigger: cfg_ff.trigger_ticks  <= csr_wdata;
            CsrSettle:  cfg_ff.settle_ticks   <= csr_wdata;
            CsrTimeout: cfg_ff.timeout_ticks  <= csr_wdata;
            CsrScale:   cfg_ff.distance_scale <= csr_wdata;
            default: ;
         endcase
      end
   end

   uer_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .cfg   (cfg_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) rsp_ff <= res;
   end

   `UER_ASSERT(a_accept_gives_word, step |=> rsp_valid_ff, "accepted word produced no result")
   `UER_ASSERT(a_word_matches, step |=> rsp_ff == $past(res), "result register lost a word")
   `UER_ASSERT_ALL(a_reset_empty, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

@@ design/uer_seq.sv @@
// Measurement sequencer: phase state, saturating counters and the distance product.
// Depends on uer_pkg and ultrasonic_echo_ranger_defines.svh.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_seq import uer_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type res
);

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] width_ff, width_in;

   logic [CountWidth-1:0] count_inc, width_inc;
   logic [ProdWidth-1:0]  prod_full;    // width_ff * distance_scale with the current scale
   logic [ProdWidth-1:0]  prod_shift;
   logic                  done;
   status_type            status;
   logic [DistWidth-1:0]  dist_val;

   function automatic logic [CountWidth-1:0] sat_inc(logic [CountWidth-1:0] v);
      return (v == CountMax) ? CountMax : v + 1'b1;
   endfunction

   function automatic logic reached(logic [CountWidth-1:0] c, logic [LimitWidth-1:0] lim);
      return (CmpWidth'(c) >= CmpWidth'(lim)) || (c == CountMax);
   endfunction

   function automatic logic passed(logic [CountWidth-1:0] c, logic [LimitWidth-1:0] lim);
      return (CmpWidth'(c) > CmpWidth'(lim)) || (c == CountMax);
   endfunction

   // zero-length timed phases fall through to the next one
   function automatic phase_type skip_empty(phase_type p, cfg_type c);
      phase_type q;
      q = p;
      if (q == PhPreLow && c.pre_low_ticks == '0) q = PhTrig;
      if (q == PhTrig && c.trigger_ticks == '0) q = PhSettle;
      if (q == PhSettle && c.settle_ticks == '0) q = PhRise;
      return q;
   endfunction

   assign count_inc  = sat_inc(count_ff);
   assign width_inc  = sat_inc(width_ff);
   assign prod_full  = ProdWidth'(width_ff) * ProdWidth'(cfg.distance_scale);
   assign prod_shift = prod_full >> ScaleShift;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      width_in = width_ff;
      done     = 1'b0;
      status   = StatusOk;
      dist_val = '0;
      case (phase_ff)
         PhIdle: begin
            if (req.start_req) begin
               phase_in = skip_empty(PhPreLow, cfg);
               count_in = '0;
            end
         end
         PhPreLow: begin
            count_in = count_inc;
            if (reached(count_inc, cfg.pre_low_ticks)) begin
               phase_in = skip_empty(PhTrig, cfg);
               count_in = '0;
            end
         end
         PhTrig: begin
            count_in = count_inc;
            if (reached(count_inc, cfg.trigger_ticks)) begin
               phase_in = skip_empty(PhSettle, cfg);
               count_in = '0;
            end
         end
         PhSettle: begin
            count_in = count_inc;
            if (reached(count_inc, cfg.settle_ticks)) begin
               phase_in = PhRise;
               count_in = '0;
            end
         end
         PhRise: begin
            if (req.echo_level) begin
               width_in = CountWidth'(1);
               count_in = '0;
               phase_in = PhWidth;
               if (passed(CountWidth'(1), cfg.timeout_ticks)) begin
                  done   = 1'b1;
                  status = StatusTooLong;
               end
            end else begin
               count_in = count_inc;
               if (passed(count_inc, cfg.timeout_ticks)) begin
                  done   = 1'b1;
                  status = StatusNoRise;
               end
            end
         end
         PhWidth: begin
            if (req.echo_level) begin
               width_in = width_inc;
               if (passed(width_inc, cfg.timeout_ticks)) begin
                  done   = 1'b1;
                  status = StatusTooLong;
               end
            end else begin
               done     = 1'b1;
               status   = StatusOk;
               dist_val = (prod_shift > ProdWidth'(DistMax)) ? DistMax
                                                             : prod_shift[DistWidth-1:0];
            end
         end
         default: begin
            phase_in = PhIdle;
            count_in = '0;
         end
      endcase
      if (done) begin
         phase_in = PhIdle;
         count_in = '0;
      end
   end

   always_comb begin
      res.trigger_level = (phase_in == PhTrig);
      res.busy_res      = (phase_in != PhIdle);
      res.done_res      = done;
      res.status        = status;
      res.distance      = dist_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         count_ff <= '0;
         width_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         width_ff <= width_in;
      end
   end

   `UER_ASSERT(a_done_to_idle, step && res.done_res |=> phase_ff == PhIdle, "done did not return to idle")
   `UER_ASSERT(a_status_needs_done, res.status != StatusOk |-> res.done_res, "status without done")
   `UER_ASSERT(a_busy_tracks_phase, step |=> (phase_ff != PhIdle) == $past(res.busy_res), "busy mismatch")
   `UER_ASSERT(a_width_phase_nonzero, phase_ff == PhWidth |-> width_ff != '0, "zero echo width")

endmodule
